FILE: hdl/sdc_pkg.sv
// shared types, constants and scancode table for the scancode decoder
`default_nettype none
package sdc_pkg;

    localparam int RING_DEPTH = 16;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    localparam logic [1:0] ACT_SCAN  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic REG_CHAR_EN = 1'b0;
    localparam logic REG_RAW_EN  = 1'b1;

    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam logic [7:0] EXT_BIT     = 8'h80;

    typedef struct packed {
        logic       we;
        logic [PTR_W-1:0] waddr;
        logic [7:0] wdata;
        logic       re;
        logic [PTR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic       char_valid;
        logic [6:0] char_code;
        logic       raw_valid;
        logic [6:0] raw_code;
        logic       raw_extended;
        logic       pop;
    } res_t;

    function automatic logic [6:0] map_ascii(input logic [6:0] code);
        logic [6:0] c;
        case (code)
            7'd1:  c = 7'd27;
            7'd2:  c = 7'h31;
            7'd3:  c = 7'h32;
            7'd4:  c = 7'h33;
            7'd5:  c = 7'h34;
            7'd6:  c = 7'h35;
            7'd7:  c = 7'h36;
            7'd8:  c = 7'h37;
            7'd9:  c = 7'h38;
            7'd10: c = 7'h39;
            7'd11: c = 7'h30;
            7'd12: c = 7'h2D;
            7'd13: c = 7'h3D;
            7'd14: c = 7'd8;
            7'd15: c = 7'd9;
            7'd16: c = 7'h71;
            7'd17: c = 7'h77;
            7'd18: c = 7'h65;
            7'd19: c = 7'h72;
            7'd20: c = 7'h74;
            7'd21: c = 7'h79;
            7'd22: c = 7'h75;
            7'd23: c = 7'h69;
            7'd24: c = 7'h6F;
            7'd25: c = 7'h70;
            7'd26: c = 7'h5B;
            7'd27: c = 7'h5D;
            7'd28: c = 7'd10;
            7'd30: c = 7'h61;
            7'd31: c = 7'h73;
            7'd32: c = 7'h64;
            7'd33: c = 7'h66;
            7'd34: c = 7'h67;
            7'd35: c = 7'h68;
            7'd36: c = 7'h6A;
            7'd37: c = 7'h6B;
            7'd38: c = 7'h6C;
            7'd39: c = 7'h3B;
            7'd40: c = 7'h27;
            7'd41: c = 7'h60;
            7'd43: c = 7'h5C;
            7'd44: c = 7'h7A;
            7'd45: c = 7'h78;
            7'd46: c = 7'h63;
            7'd47: c = 7'h76;
            7'd48: c = 7'h62;
            7'd49: c = 7'h6E;
            7'd50: c = 7'h6D;
            7'd51: c = 7'h2C;
            7'd52: c = 7'h2E;
            7'd53: c = 7'h2F;
            7'd55: c = 7'h2A;
            7'd57: c = 7'h20;
            7'd74: c = 7'h2D;
            7'd78: c = 7'h2B;
            default: c = 7'd0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/scancode_decoder_with_key_fifo.sv
// top level: scancode decoder with key ring held in a ram
// the result is registered on accept; the popped key comes from the ram read register
// throughput: one request per cycle; s_ready is low only while a result waits with m_ready low
// reset: synchronous active-low aresetn clears enables, prefix flag, pointers and output valid
// ring contents are not cleared by reset; no clearing pass is needed
`default_nettype none
module scancode_decoder_with_key_fifo (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic       cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_action,
    input  wire logic [7:0] s_scancode,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_char_valid,
    output logic [6:0]      m_char_code,
    output logic            m_raw_valid,
    output logic [6:0]      m_raw_code,
    output logic            m_raw_extended,
    output logic [7:0]      m_key_data
);
    import sdc_pkg::*;

    logic     accept;
    logic     out_valid_reg, out_valid_next;
    ram_req_t ram_req;
    res_t     res;
    res_t     res_reg;
    logic [7:0] ram_rdata;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    sdc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .action    (s_action),
        .scancode  (s_scancode),
        .ram_req   (ram_req),
        .res       (res)
    );

    sdc_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_char_valid   = res_reg.char_valid;
    assign m_char_code    = res_reg.char_code;
    assign m_raw_valid    = res_reg.raw_valid;
    assign m_raw_code     = res_reg.raw_code;
    assign m_raw_extended = res_reg.raw_extended;
    assign m_key_data     = res_reg.pop ? ram_rdata : 8'h00;
endmodule
`default_nettype wire

FILE: hdl/sdc_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none
module sdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

FILE: hdl/sdc_ctrl.sv
// request decode, ring pointers, prefix flag and configuration registers
`default_nettype none
module sdc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic              cfg_wdata,
    input  wire logic              accept,
    input  wire logic [1:0]        action,
    input  wire logic [7:0]        scancode,
    output sdc_pkg::ram_req_t      ram_req,
    output sdc_pkg::res_t          res
);
    import sdc_pkg::*;

    logic             char_en_reg, char_en_next;
    logic             raw_en_reg, raw_en_next;
    logic             prefix_reg, prefix_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_inc, rd_inc;
    logic [6:0]       ascii;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    assign wr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign ascii  = map_ascii(scancode[6:0]);

    always_comb begin
        char_en_next = char_en_reg;
        raw_en_next  = raw_en_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_CHAR_EN: char_en_next = cfg_wdata;
                REG_RAW_EN:  raw_en_next  = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        prefix_next   = prefix_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = wr_ptr_reg;
        ram_req.wdata = scancode | (prefix_reg ? EXT_BIT : 8'h00);
        ram_req.re    = 1'b0;
        ram_req.raddr = rd_ptr_reg;
        res           = '0;
        if (accept) begin
            case (action)
                ACT_SCAN: begin
                    if (scancode == PREFIX_BYTE) begin
                        prefix_next = 1'b1;
                    end else begin
                        prefix_next = 1'b0;
                        if (!scancode[7]) begin
                            if (wr_inc != rd_ptr_reg) begin
                                ram_req.we  = 1'b1;
                                wr_ptr_next = wr_inc;
                            end
                            if (raw_en_reg) begin
                                res.raw_valid    = 1'b1;
                                res.raw_code     = scancode[6:0];
                                res.raw_extended = prefix_reg;
                            end
                            if (char_en_reg && ascii != 7'd0) begin
                                res.char_valid = 1'b1;
                                res.char_code  = ascii;
                            end
                        end
                    end
                end
                ACT_READ: begin
                    if (rd_ptr_reg != wr_ptr_reg) begin
                        ram_req.re  = 1'b1;
                        res.pop     = 1'b1;
                        rd_ptr_next = rd_inc;
                    end
                end
                ACT_CLEAR: begin
                    wr_ptr_next = '0;
                    rd_ptr_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_en_reg <= 1'b0;
            raw_en_reg  <= 1'b0;
            prefix_reg  <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
        end else begin
            char_en_reg <= char_en_next;
            raw_en_reg  <= raw_en_next;
            prefix_reg  <= prefix_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/sdc_checker.sv
// port-level assertions for the scancode decoder and their bind
`default_nettype none
module sdc_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_char_valid,
    input wire logic [6:0] m_char_code,
    input wire logic       m_raw_valid,
    input wire logic [6:0] m_raw_code,
    input wire logic       m_raw_extended
);
    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_request_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted request produced no result");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("request taken while result stalled");

    a_char_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_char_valid |-> m_char_code != 7'd0)
        else $error("character valid with zero code");

    a_raw_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_raw_valid |-> m_raw_code == 7'd0 && !m_raw_extended)
        else $error("raw fields nonzero without raw event");
endmodule

bind scancode_decoder_with_key_fifo sdc_checker u_sdc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_char_valid   (m_char_valid),
    .m_char_code    (m_char_code),
    .m_raw_valid    (m_raw_valid),
    .m_raw_code     (m_raw_code),
    .m_raw_extended (m_raw_extended)
);
`default_nettype wire

FILE: bench/scancode_decoder_with_key_fifo_tb.sv
// self-checking testbench for the scancode decoder with key ring
`timescale 1ns / 1ps
module scancode_decoder_with_key_fifo_tb;
    import sdc_pkg::*;

    localparam logic [1:0] ACT_RSVD = 2'd3;
    localparam int MAP_ENTRIES   = 90;
    localparam int DIRECTED_ROWS = 25;
    localparam int CONFIG_ROW    = 3;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 275;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 1000;
    localparam int PRINT_CAP     = 40;

    typedef struct packed {
        logic       char_valid;
        logic [6:0] char_code;
        logic       raw_valid;
        logic [6:0] raw_code;
        logic       raw_extended;
        logic [7:0] key_data;
    } key_result_t;

    typedef struct packed {
        logic [1:0]  act;
        logic [7:0]  code;
        logic        typed;
        key_result_t want;
    } stim_row_t;

    localparam key_result_t NO_RESULT = '0;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       cfg_we         = 1'b0;
    logic       cfg_index      = 1'b0;
    logic       cfg_wdata      = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [1:0] s_action       = 2'd0;
    logic [7:0] s_scancode     = 8'h00;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic       m_char_valid;
    logic [6:0] m_char_code;
    logic       m_raw_valid;
    logic [6:0] m_raw_code;
    logic       m_raw_extended;
    logic [7:0] m_key_data;

    scancode_decoder_with_key_fifo DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_scancode     (s_scancode),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_char_valid   (m_char_valid),
        .m_char_code    (m_char_code),
        .m_raw_valid    (m_raw_valid),
        .m_raw_code     (m_raw_code),
        .m_raw_extended (m_raw_extended),
        .m_key_data     (m_key_data)
    );

    always #4 aclk = ~aclk;

    // us layout, set 1 codes 0..89
    logic [6:0] ascii_of_code [MAP_ENTRIES] = '{
        'h00, 'h1B, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36, 'h37, 'h38, 'h39, 'h30, 'h2D, 'h3D, 'h08,
        'h09, 'h71, 'h77, 'h65, 'h72, 'h74, 'h79, 'h75, 'h69, 'h6F, 'h70, 'h5B, 'h5D, 'h0A,
        'h00, 'h61, 'h73, 'h64, 'h66, 'h67, 'h68, 'h6A, 'h6B, 'h6C, 'h3B, 'h27, 'h60,
        'h00, 'h5C, 'h7A, 'h78, 'h63, 'h76, 'h62, 'h6E, 'h6D, 'h2C, 'h2E, 'h2F, 'h00,
        'h2A, 'h00, 'h20, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
        'h00, 'h00, 'h00, 'h00, 'h00,
        'h2D, 'h00, 'h00, 'h00, 'h2B, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
        'h00, 'h00
    };

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ACT_READ,  8'h00, 1'b1, NO_RESULT},
        '{ACT_SCAN,  8'h1E, 1'b1, NO_RESULT},
        '{ACT_READ,  8'h00, 1'b1, '{1'b0, 7'h00, 1'b0, 7'h00, 1'b0, 8'h1E}},
        '{ACT_SCAN,  8'h1E, 1'b1, '{1'b1, 7'h61, 1'b1, 7'h1E, 1'b0, 8'h00}},
        '{ACT_SCAN,  8'hE0, 1'b1, NO_RESULT},
        '{ACT_SCAN,  8'h1C, 1'b0, NO_RESULT},
        '{ACT_SCAN,  8'h9C, 1'b1, NO_RESULT},
        '{ACT_SCAN,  8'hE0, 1'b1, NO_RESULT},
        '{ACT_SCAN,  8'h9C, 1'b1, NO_RESULT},
        '{ACT_SCAN,  8'h10, 1'b0, NO_RESULT},
        '{ACT_SCAN,  8'h00, 1'b0, NO_RESULT},
        '{ACT_SCAN,  8'h7F, 1'b0, NO_RESULT},
        '{ACT_SCAN,  8'h5A, 1'b0, NO_RESULT},
        '{ACT_SCAN,  8'h59, 1'b0, NO_RESULT},
        '{ACT_SCAN,  8'h4E, 1'b0, NO_RESULT},
        '{ACT_SCAN,  8'hFF, 1'b1, NO_RESULT},
        '{ACT_RSVD,  8'hFF, 1'b1, NO_RESULT},
        '{ACT_SCAN,  8'hE0, 1'b1, NO_RESULT},
        '{ACT_READ,  8'h00, 1'b0, NO_RESULT},
        '{ACT_CLEAR, 8'h00, 1'b1, NO_RESULT},
        '{ACT_READ,  8'h00, 1'b1, NO_RESULT},
        '{ACT_SCAN,  8'h01, 1'b0, NO_RESULT},
        '{ACT_READ,  8'h00, 1'b0, NO_RESULT},
        '{ACT_READ,  8'h00, 1'b1, NO_RESULT},
        '{ACT_SCAN,  8'h80, 1'b1, NO_RESULT}
    };

    int phase_char [PHASES]    = '{0, 1, 0, 1, 1, 0};
    int phase_raw  [PHASES]    = '{0, 0, 1, 1, 1, 0};
    int phase_read_pct [PHASES] = '{30, 10, 35, 5, 25, 20};

    // predictor state
    logic       char_on      = 1'b0;
    logic       raw_on       = 1'b0;
    logic       prefix_armed = 1'b0;
    logic [7:0] key_slots [RING_DEPTH];
    int         wr_ptr       = 0;
    int         rd_ptr       = 0;

    key_result_t pending_results [$];
    logic [7:0]  typing_bytes [$];
    int          error_count   = 0;
    bit          hold_receiver = 1'b0;
    bit          sender_steady = 1'b0;
    int          offered       = 0;

    function automatic key_result_t decode_request(input logic [1:0] act,
                                                   input logic [7:0] code);
        key_result_t r;
        int nxt;
        r = '0;
        case (act)
            ACT_SCAN: begin
                if (code == PREFIX_BYTE) begin
                    prefix_armed = 1'b1;
                end else begin
                    if (!code[7]) begin
                        nxt = (wr_ptr + 1) % RING_DEPTH;
                        if (nxt != rd_ptr) begin
                            key_slots[wr_ptr] = code | (prefix_armed ? EXT_BIT : 8'h00);
                            wr_ptr = nxt;
                        end
                        if (raw_on) begin
                            r.raw_valid    = 1'b1;
                            r.raw_code     = code[6:0];
                            r.raw_extended = prefix_armed;
                        end
                        if (char_on && code < MAP_ENTRIES) begin
                            if (ascii_of_code[code] != 7'd0) begin
                                r.char_valid = 1'b1;
                                r.char_code  = ascii_of_code[code];
                            end
                        end
                    end
                    prefix_armed = 1'b0;
                end
            end
            ACT_READ: begin
                if (rd_ptr != wr_ptr) begin
                    r.key_data = key_slots[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                end
            end
            ACT_CLEAR: begin
                wr_ptr = 0;
                rd_ptr = 0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < PRINT_CAP)
            $display("%0t mismatch %s: got 'h%0h, want 'h%0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_request(input logic [1:0] act, input logic [7:0] code,
                                input logic typed, input key_result_t want);
        int gap;
        key_result_t predicted;
        if (offered % 64 == 0)
            sender_steady = ($urandom_range(0, 2) == 0);
        offered++;
        gap = sender_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= act;
        s_scancode <= code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = decode_request(act, code);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic char_val, input logic raw_val);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CHAR_EN;
        cfg_wdata <= char_val;
        @(posedge aclk);
        cfg_index <= REG_RAW_EN;
        cfg_wdata <= raw_val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        char_on = char_val;
        raw_on  = raw_val;
    endtask

    task automatic pick_request(input int read_pct, output logic [1:0] act,
                                output logic [7:0] code);
        int roll;
        logic [7:0] key;
        bit ext;
        roll = $urandom_range(0, 99);
        act  = ACT_SCAN;
        code = 8'h00;
        if (typing_bytes.size() != 0) begin
            code = typing_bytes.pop_front();
        end else if (roll < read_pct) begin
            act = ACT_READ;
            code = 8'($urandom_range(0, 255));
        end else if (roll < read_pct + 4) begin
            act = ACT_CLEAR;
            code = 8'($urandom_range(0, 255));
        end else if (roll < read_pct + 6) begin
            act = ACT_RSVD;
            code = 8'($urandom_range(0, 255));
        end else if (roll < read_pct + 14) begin
            code = 8'($urandom_range(0, 255));
        end else begin
            // press with optional prefix, usually followed by its release
            key = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, MAP_ENTRIES - 1))
                                              : 8'($urandom_range(0, 127));
            ext = ($urandom_range(0, 3) == 0);
            if (ext) typing_bytes.push_back(PREFIX_BYTE);
            typing_bytes.push_back(key);
            if ($urandom_range(0, 3) != 0) begin
                if (ext) typing_bytes.push_back(PREFIX_BYTE);
                typing_bytes.push_back(key | 8'h80);
            end
            code = typing_bytes.pop_front();
        end
    endtask

    always @(posedge aclk) begin
        key_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", m_key_data, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_char_valid !== want.char_valid)
                    report_mismatch("char_valid", m_char_valid, want.char_valid);
                if (m_char_code !== want.char_code)
                    report_mismatch("char_code", m_char_code, want.char_code);
                if (m_raw_valid !== want.raw_valid)
                    report_mismatch("raw_valid", m_raw_valid, want.raw_valid);
                if (m_raw_code !== want.raw_code)
                    report_mismatch("raw_code", m_raw_code, want.raw_code);
                if (m_raw_extended !== want.raw_extended)
                    report_mismatch("raw_extended", m_raw_extended, want.raw_extended);
                if (m_key_data !== want.key_data)
                    report_mismatch("key_data", m_key_data, want.key_data);
            end
        end
    end

    // result side
    initial begin
        int stall;
        int served;
        bit steady;
        served = 0;
        steady = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (served % 64 == 0)
                steady = ($urandom_range(0, 2) == 0);
            if (hold_receiver) begin
                stall = HOLD_CYCLES;
                hold_receiver = 1'b0;
            end else begin
                stall = steady ? 0 : $urandom_range(0, 15);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            served++;
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || cfg_we || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int counted;
        logic [1:0] act;
        logic [7:0] code;
        aresetn <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (i == CONFIG_ROW) begin
                drain_results();
                apply_settings(1'b1, 1'b1);
            end
            send_request(directed_rows[i].act, directed_rows[i].code,
                         directed_rows[i].typed, directed_rows[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            apply_settings(phase_char[p][0], phase_raw[p][0]);
            if (p == 3)
                hold_receiver = 1'b1;
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                pick_request(phase_read_pct[p], act, code);
                send_request(act, code, 1'b0, NO_RESULT);
                counted++;
                if (p == 1 && counted == PHASE_ITEMS / 2)
                    drain_results();
            end
        end

        drain_results();
        repeat (4) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
hdl/sdc_pkg.sv
hdl/sdc_ram.sv
hdl/sdc_ctrl.sv
hdl/scancode_decoder_with_key_fifo.sv
hdl/sdc_checker.sv
bench/scancode_decoder_with_key_fifo_tb.sv
